// ===== rtl/msq_pkg.sv =====
// ----------------------------------------------------------------------------
// msq_pkg: shared types and tables for the cut-plane triangulator
// Item and result words, queue entry, coordinate codes and the per-case
// vertex table with its winding order.
// ----------------------------------------------------------------------------
package msq_pkg;

  localparam int unsigned NUM_CASES   = 16;
  localparam int unsigned MAX_VERTS   = 9;
  localparam int unsigned NUM_DIST    = 8;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef logic [3:0] vcount_t;
  typedef logic [3:0] vidx_t;

  typedef struct packed {
    logic [3:0] corner_mask;
    logic [7:0] dist_c00_px;
    logic [7:0] dist_c00_py;
    logic [7:0] dist_c10_nx;
    logic [7:0] dist_c10_py;
    logic [7:0] dist_c01_ny;
    logic [7:0] dist_c01_px;
    logic [7:0] dist_c11_nx;
    logic [7:0] dist_c11_ny;
  } in_item_t;

  typedef struct packed {
    logic [7:0] vert_u;
    logic [7:0] vert_v;
    logic       last_vertex;
  } out_item_t;

  typedef struct packed {
    in_item_t item;
    vcount_t  count;
  } q_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Coordinate code: kind in [4:3], distance index in [2:0]
  typedef logic [1:0] coord_kind_t;
  localparam coord_kind_t KIND_ZERO = 2'd0;
  localparam coord_kind_t KIND_ONE  = 2'd1;
  localparam coord_kind_t KIND_DIST = 2'd2;
  localparam coord_kind_t KIND_REV  = 2'd3;

  typedef logic [4:0] coord_code_t;
  typedef logic [9:0] coord_pair_t;  // {u code, v code}

  localparam coord_code_t C_Z = {KIND_ZERO, 3'd0};
  localparam coord_code_t C_O = {KIND_ONE,  3'd0};
  localparam coord_code_t D0  = {KIND_DIST, 3'd0};
  localparam coord_code_t D1  = {KIND_DIST, 3'd1};
  localparam coord_code_t D3  = {KIND_DIST, 3'd3};
  localparam coord_code_t D5  = {KIND_DIST, 3'd5};
  localparam coord_code_t R2  = {KIND_REV,  3'd2};
  localparam coord_code_t R4  = {KIND_REV,  3'd4};
  localparam coord_code_t R6  = {KIND_REV,  3'd6};
  localparam coord_code_t R7  = {KIND_REV,  3'd7};
  localparam coord_pair_t NONE = {C_Z, C_Z};

  localparam vcount_t VERT_COUNT [NUM_CASES] = '{
    4'd0, 4'd3, 4'd3, 4'd6, 4'd3, 4'd6, 4'd6, 4'd9,
    4'd3, 4'd6, 4'd6, 4'd9, 4'd6, 4'd9, 4'd9, 4'd6
  };

  localparam coord_pair_t VERT_TABLE [NUM_CASES][MAX_VERTS] = '{
    '{NONE, NONE, NONE, NONE, NONE, NONE, NONE, NONE, NONE},
    '{{R2,C_Z}, {C_Z,R4}, {C_Z,C_Z}, NONE, NONE, NONE, NONE, NONE, NONE},
    '{{D0,C_Z}, {C_O,C_Z}, {C_O,R7}, NONE, NONE, NONE, NONE, NONE, NONE},
    '{{C_Z,R4}, {C_Z,C_Z}, {C_O,C_Z}, {C_Z,R4}, {C_O,C_Z}, {C_O,R7},
      NONE, NONE, NONE},
    '{{D5,C_O}, {C_O,D3}, {C_O,C_O}, NONE, NONE, NONE, NONE, NONE, NONE},
    '{{C_Z,R4}, {C_Z,C_Z}, {R2,C_Z}, {D5,C_O}, {C_O,D3}, {C_O,C_O},
      NONE, NONE, NONE},
    '{{D5,C_O}, {D0,C_Z}, {C_O,C_O}, {C_O,C_O}, {D0,C_Z}, {C_O,C_Z},
      NONE, NONE, NONE},
    '{{C_Z,R4}, {C_Z,C_Z}, {C_O,C_Z}, {C_O,C_Z}, {D5,C_O}, {C_Z,R4},
      {C_O,C_Z}, {C_O,C_O}, {D5,C_O}},
    '{{C_Z,D1}, {R6,C_O}, {C_Z,C_O}, NONE, NONE, NONE, NONE, NONE, NONE},
    '{{C_Z,C_O}, {C_Z,C_Z}, {R6,C_O}, {R6,C_O}, {C_Z,C_Z}, {R2,C_Z},
      NONE, NONE, NONE},
    '{{C_Z,C_O}, {C_Z,D1}, {R6,C_O}, {D0,C_Z}, {C_O,C_Z}, {C_O,R7},
      NONE, NONE, NONE},
    '{{R6,C_O}, {C_Z,C_O}, {C_Z,C_Z}, {C_Z,C_Z}, {C_O,R7}, {R6,C_O},
      {C_Z,C_Z}, {C_O,C_Z}, {C_O,R7}},
    '{{C_Z,C_O}, {C_Z,D1}, {C_O,D3}, {C_O,D3}, {C_O,C_O}, {C_Z,C_O},
      NONE, NONE, NONE},
    '{{C_Z,C_O}, {C_Z,C_Z}, {R2,C_Z}, {R2,C_Z}, {C_O,D3}, {C_Z,C_O},
      {C_Z,C_O}, {C_O,D3}, {C_O,C_O}},
    '{{C_Z,C_O}, {C_Z,D1}, {C_O,C_O}, {C_O,C_O}, {C_Z,D1}, {D0,C_Z},
      {D0,C_Z}, {C_O,C_Z}, {C_O,C_O}},
    '{{C_Z,C_Z}, {C_O,C_Z}, {C_Z,C_O}, {C_O,C_O}, {C_Z,C_O}, {C_O,C_Z},
      NONE, NONE, NONE}
  };

endpackage

// ===== rtl/marching_squares_cut_plane_triangulator_core.sv =====
// ----------------------------------------------------------------------------
// marching_squares_cut_plane_triangulator_core: square to triangle vertices
// Turns one cut-plane square (corner mask plus NUM_DIST edge distances) into
// the vertices of its filled triangles, one vertex per output word.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one word per square, valid/ready. Squares with mask 0 are taken
//           and produce nothing.
//   out_* : one word per vertex, valid/ready, in table winding order;
//           last_vertex marks the final vertex of each square (3, 6 or 9).
//   Path: the first vertex of a square passes the intake register, then a
//   queue entry, then the output register, where out_valid shows it.
//   Throughput: one vertex per cycle while the receiver does not stall, set by
//   the single output register fed by the sequencer; a square has at most nine
//   vertices, and an empty square is dropped from the intake register.
//   The intake register and a two-entry queue keep taking squares while the
//   sequencer works, so intake runs ahead of output by up to three squares.
//   Receiver stall: the output word holds, the sequencer freezes, the queue
//   fills, and then in_ready drops. No vertex is lost or repeated.
//   Reset (rst_n low, synchronous): empties the intake register, the queue
//   and the output register; no state survives between squares.
// ----------------------------------------------------------------------------
module marching_squares_cut_plane_triangulator_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  msq_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output msq_pkg::out_item_t out_data
);

  // Front to queue: classified square, dropped here if it has no vertices
  logic             push;
  msq_pkg::q_item_t push_data;

  // Queue to back: head square and fill status
  msq_pkg::q_item_t head;
  msq_pkg::q_stat_t q_stat;
  logic             pop;

  // Intake: register the square and look up its vertex count
  msq_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .q_stat    (q_stat),
    .push      (push),
    .push_data (push_data)
  );

  // Decouple intake from vertex emission
  msq_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .q_stat    (q_stat)
  );

  // Emit the head square's vertices; pop on its last vertex
  msq_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .q_stat    (q_stat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== rtl/msq_front.sv =====
// ----------------------------------------------------------------------------
// msq_front: intake register and case classification
// Registers one square, looks up its vertex count and hands it to the
// queue; squares with no vertices are dropped here.
// ----------------------------------------------------------------------------
module msq_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  msq_pkg::in_item_t in_data,
  input  msq_pkg::q_stat_t  q_stat,
  output logic              push,
  output msq_pkg::q_item_t  push_data
);

  logic              valid_r;
  logic              valid_nxt;
  msq_pkg::in_item_t item_r;
  msq_pkg::vcount_t  count_r;
  logic              empty_case;
  logic              advance;
  logic              accept;

  assign empty_case = (count_r == '0);
  assign advance    = valid_r && (empty_case || !q_stat.full);
  assign push       = valid_r && !empty_case && !q_stat.full;
  assign in_ready   = !valid_r || advance;
  assign accept     = in_valid && in_ready;

  assign push_data.item  = item_r;
  assign push_data.count = count_r;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload: capture on accept
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r  <= in_data;
      count_r <= msq_pkg::VERT_COUNT[in_data.corner_mask];
    end
  end

endmodule

// ===== rtl/msq_queue.sv =====
// ----------------------------------------------------------------------------
// msq_queue: short queue between intake and vertex sequencer
// Register-based FIFO; the head entry is visible without a read cycle.
// ----------------------------------------------------------------------------
module msq_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  msq_pkg::q_item_t  push_data,
  input  logic              pop,
  output msq_pkg::q_item_t  head,
  output msq_pkg::q_stat_t  q_stat
);

  localparam logic [msq_pkg::QPTR_W-1:0] PTR_LAST =
    msq_pkg::QPTR_W'(msq_pkg::QUEUE_DEPTH - 1);
  localparam logic [msq_pkg::QCNT_W-1:0] CNT_FULL =
    msq_pkg::QCNT_W'(msq_pkg::QUEUE_DEPTH);

  msq_pkg::q_item_t              entry_r [msq_pkg::QUEUE_DEPTH];
  logic [msq_pkg::QPTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [msq_pkg::QPTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [msq_pkg::QCNT_W-1:0]    cnt_r, cnt_nxt;
  logic                          do_push;
  logic                          do_pop;

  assign q_stat.full  = (cnt_r == CNT_FULL);
  assign q_stat.empty = (cnt_r == '0);
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign head         = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    unique case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== rtl/msq_back.sv =====
// ----------------------------------------------------------------------------
// msq_back: vertex sequencer and output register
// Walks the queue head's case table one vertex per cycle unless the output
// stalls, decodes the coordinate codes and holds each vertex until taken.
// ----------------------------------------------------------------------------
module msq_back (
  input  logic               clk,
  input  logic               rst_n,
  input  msq_pkg::q_item_t   head,
  input  msq_pkg::q_stat_t   q_stat,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output msq_pkg::out_item_t out_data
);

  function automatic logic [7:0] decode_coord(
    input msq_pkg::coord_code_t code,
    input logic [7:0]           dv [msq_pkg::NUM_DIST]
  );
    logic [7:0] d;
    d = dv[code[2:0]];
    unique case (msq_pkg::coord_kind_t'(code[4:3]))
      msq_pkg::KIND_ZERO: decode_coord = 8'd0;
      msq_pkg::KIND_ONE:  decode_coord = 8'd255;
      msq_pkg::KIND_DIST: decode_coord = d;
      msq_pkg::KIND_REV:  decode_coord = 8'd255 - d;
      default:            decode_coord = 8'd0;
    endcase
  endfunction

  logic                 out_valid_r, out_valid_nxt;
  msq_pkg::out_item_t   out_data_r;
  msq_pkg::vidx_t       k_r, k_nxt;
  logic [7:0]           dist_v [msq_pkg::NUM_DIST];
  msq_pkg::coord_pair_t pair;
  logic                 load;
  logic                 emit;
  logic                 last;

  assign dist_v[0] = head.item.dist_c00_px;
  assign dist_v[1] = head.item.dist_c00_py;
  assign dist_v[2] = head.item.dist_c10_nx;
  assign dist_v[3] = head.item.dist_c10_py;
  assign dist_v[4] = head.item.dist_c01_ny;
  assign dist_v[5] = head.item.dist_c01_px;
  assign dist_v[6] = head.item.dist_c11_nx;
  assign dist_v[7] = head.item.dist_c11_ny;

  assign pair = msq_pkg::VERT_TABLE[head.item.corner_mask][k_r];
  assign load = !out_valid_r || out_ready;
  assign emit = load && !q_stat.empty;
  assign last = (k_r == head.count - 1'b1);
  assign pop  = emit && last;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    k_nxt         = k_r;
    out_valid_nxt = out_valid_r;
    if (emit) begin
      k_nxt         = last ? '0 : k_r + 1'b1;
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      k_r         <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      k_r         <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r.vert_u      <= decode_coord(pair[9:5], dist_v);
      out_data_r.vert_v      <= decode_coord(pair[4:0], dist_v);
      out_data_r.last_vertex <= last;
    end
  end

  // vertex index stays inside the head square's run
  a_k_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    !q_stat.empty |-> (k_r < head.count))
    else $error("vertex index past end of run");

  // no partial run is left behind when the queue drains
  a_k_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.empty |-> (k_r == '0))
    else $error("vertex index nonzero with empty queue");

  // a stalled vertex freezes the sequencer
  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> ($stable(k_r) && !$past(pop)))
    else $error("sequencer advanced during stall");

endmodule
